/* hw/rtl/cfre_pkg.sv */
// Shared widths, port layout and sequencer states of the clock frequency ratio estimator.
package cfre_pkg;

  localparam int ARRIVAL_W  = 48;
  localparam int STAMP_W    = 32;
  localparam int AGAP_W     = 49;
  localparam int DGAP_W     = 33;
  localparam int RATIO_W    = 64;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 296;
  localparam int OUT_USER_W = 2;

  // out_tdata layout, lowest bit first
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * (AGAP_W + DGAP_W + RATIO_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRACK,
    ST_DIV_ALL,
    ST_DIV_FRAME,
    ST_OUT
  } seq_state_t;

endpackage

/* hw/rtl/cfre_track.sv */
// One measurement track: previous counter and stamp, wrapped gap calculation.
module cfre_track
  import cfre_pkg::*;
#(
  parameter int CW = 48,
  parameter int SW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          en,
  input  logic [CW-1:0] arrival,
  input  logic [SW-1:0] stamp,
  output logic          valid,
  output logic [CW:0]   arrival_gap,
  output logic [SW:0]   departure_gap
);

  logic [CW-1:0] prev_arrival_r;
  logic [SW-1:0] prev_stamp_r;
  logic          have_prev_r;
  logic          valid_r;
  logic [CW:0]   agap_r;
  logic [SW:0]   dgap_r;

  logic [CW-1:0] adiff;
  logic [SW-1:0] sdiff;
  logic [CW:0]   agap_nxt;
  logic [SW:0]   dgap_nxt;

  // equal values wrap to the full modulus
  always_comb begin
    adiff    = arrival - prev_arrival_r;
    sdiff    = stamp - prev_stamp_r;
    agap_nxt = (adiff == '0) ? {1'b1, {CW{1'b0}}} : {1'b0, adiff};
    dgap_nxt = (sdiff == '0) ? {1'b1, {SW{1'b0}}} : {1'b0, sdiff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_arrival_r <= '0;
      prev_stamp_r   <= '0;
      have_prev_r    <= 1'b0;
      valid_r        <= 1'b0;
    end else if (load && en) begin
      prev_arrival_r <= arrival;
      prev_stamp_r   <= stamp;
      have_prev_r    <= 1'b1;
      valid_r        <= have_prev_r;
    end else if (load) begin
      valid_r        <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      agap_r <= (en && have_prev_r) ? agap_nxt : '0;
      dgap_r <= (en && have_prev_r) ? dgap_nxt : '0;
    end
  end

  assign valid         = valid_r;
  assign arrival_gap   = agap_r;
  assign departure_gap = dgap_r;

endmodule

/* hw/rtl/cfre_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, saturating 64-bit ratio.
module cfre_divider
  import cfre_pkg::*;
#(
  parameter int CW = 48,
  parameter int SW = 32,
  parameter int F  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [CW:0]        num,
  input  logic [SW:0]        den,
  output logic               busy,
  output logic               done,
  output logic [RATIO_W-1:0] ratio
);

  localparam int NUM_W = CW + 1 + F;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [SW:0]      rem_r;
  logic [SW:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [SW+1:0]    trial;
  logic [SW+1:0]    diff;
  logic             ge;
  logic [SW:0]      rem_nxt;

  // remainder stays below the divisor, so it fits SW+1 bits
  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[SW:0] : trial[SW:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= NUM_W'(num) << F;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  generate
    if (NUM_W > RATIO_W) begin : g_sat
      assign ratio = (|quo_r[NUM_W-1:RATIO_W]) ? {RATIO_W{1'b1}} : quo_r[RATIO_W-1:0];
    end else begin : g_nosat
      assign ratio = RATIO_W'(quo_r);
    end
  endgenerate

  assign busy = busy_r;
  assign done = done_r;

endmodule

/* hw/rtl/clock_frequency_ratio_estimator.sv */
// Top level: two gap tracks, shared serial divider, sequencer and output register.
//
// Channel  Direction  Carries
// in_      slave      arrival_count, sender_stamp (tdata); frame_start (tuser)
// out_     master     gaps and ratios of both tracks (tdata); valid flags (tuser)
//
// Each measuring track runs the one-bit-per-cycle divider once between acceptance and
// out_tvalid; an item without a measurement passes from the track stage straight to the
// output stage.
// Synchronous reset clears the tracks' previous values and flags and empties the output.
// A new item is taken while a finished result waits; a stalled output holds the
// sequencer before it loads the next result.
module clock_frequency_ratio_estimator
  import cfre_pkg::*;
#(
  parameter int COUNT_WIDTH   = 48,
  parameter int STAMP_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // arrival_count[47:0], sender_stamp[79:48]
  input  logic [IN_USER_W-1:0]  in_tuser,   // frame_start[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // all_arrival_gap, all_departure_gap, all_ratio,
  // frame_arrival_gap, frame_departure_gap, frame_ratio, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser   // all_valid[0], frame_valid[1]
);

  localparam int CW = COUNT_WIDTH;
  localparam int SW = STAMP_WIDTH;

  seq_state_t state_r, state_nxt;

  logic               in_acc;
  logic [CW-1:0]      arrival;
  logic [SW-1:0]      stamp;

  logic               all_valid, frame_valid;
  logic [CW:0]        all_agap, frame_agap;
  logic [SW:0]        all_dgap, frame_dgap;

  logic               div_start, div_sel_frame, div_busy, div_done;
  logic [CW:0]        div_num;
  logic [SW:0]        div_den;
  logic [RATIO_W-1:0] div_ratio;

  logic               cap_all, cap_frame, clr_ratio, load_out;
  logic [RATIO_W-1:0] all_ratio_r, frame_ratio_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_USER_W-1:0] out_tuser_r;

  assign in_acc  = in_tvalid && in_tready;
  assign arrival = in_tdata[CW-1:0];
  assign stamp   = in_tdata[ARRIVAL_W +: SW];

  cfre_track #(.CW(CW), .SW(SW)) u_track_all (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_acc),
    .en            (1'b1),
    .arrival       (arrival),
    .stamp         (stamp),
    .valid         (all_valid),
    .arrival_gap   (all_agap),
    .departure_gap (all_dgap)
  );

  cfre_track #(.CW(CW), .SW(SW)) u_track_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_acc),
    .en            (in_tuser[0]),
    .arrival       (arrival),
    .stamp         (stamp),
    .valid         (frame_valid),
    .arrival_gap   (frame_agap),
    .departure_gap (frame_dgap)
  );

  assign div_num = div_sel_frame ? frame_agap : all_agap;
  assign div_den = div_sel_frame ? frame_dgap : all_dgap;

  cfre_divider #(.CW(CW), .SW(SW), .F(FRACTION_BITS)) u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .ratio (div_ratio)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_TRACK;
      end
      ST_TRACK: begin
        if (all_valid)        state_nxt = ST_DIV_ALL;
        else if (frame_valid) state_nxt = ST_DIV_FRAME;
        else                  state_nxt = ST_OUT;
      end
      ST_DIV_ALL: begin
        if (div_done) state_nxt = frame_valid ? ST_DIV_FRAME : ST_OUT;
      end
      ST_DIV_FRAME: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    div_start     = 1'b0;
    div_sel_frame = 1'b0;
    cap_all       = 1'b0;
    cap_frame     = 1'b0;
    clr_ratio     = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_TRACK: begin
        clr_ratio     = 1'b1;
        div_start     = all_valid || frame_valid;
        div_sel_frame = !all_valid;
      end
      ST_DIV_ALL: begin
        cap_all       = div_done;
        div_start     = div_done && frame_valid;
        div_sel_frame = 1'b1;
      end
      ST_DIV_FRAME: begin
        cap_frame     = div_done;
        div_sel_frame = 1'b1;
      end
      ST_OUT: load_out = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_ratio) begin
      all_ratio_r   <= '0;
      frame_ratio_r <= '0;
    end else begin
      if (cap_all)   all_ratio_r   <= div_ratio;
      if (cap_frame) frame_ratio_r <= div_ratio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}},
                      frame_ratio_r, DGAP_W'(frame_dgap), AGAP_W'(frame_agap),
                      all_ratio_r,   DGAP_W'(all_dgap),   AGAP_W'(all_agap)};
      out_tuser_r <= {frame_valid, all_valid};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef ASSERT_OFF
  a_frame_implies_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tuser[0]))
    else $error("frame track measured without the all track");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_gaps_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |->
      (out_tdata[AGAP_W-1:0] != '0) && (out_tdata[AGAP_W +: DGAP_W] != '0))
    else $error("measured item carries a zero gap");

  a_accept_to_track: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_TRACK))
    else $error("accepted item did not reach the track stage");
`endif

endmodule
